// ----- sv/opdec_pkg.sv -----
// ----------------------------------------------------------------------------
// opdec_pkg
// Types, instruction class codes and opcode constants for the opcode decoder.
// ----------------------------------------------------------------------------
package opdec_pkg;

  localparam int AddrW  = 16;
  localparam int ByteW  = 8;
  localparam int ClassW = 6;
  localparam int FieldW = 3;
  localparam int LenW   = 2;

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [ClassW-1:0] class_t;
  typedef logic [FieldW-1:0] field_t;
  typedef logic [LenW-1:0]   len_t;

  typedef struct packed {
    addr_t instr_address;
    byte_t opcode_byte;
    byte_t next_byte;
    byte_t third_byte;
  } window_t;

  typedef struct packed {
    class_t instr_class;
    field_t first_field;
    field_t second_field;
    addr_t  operand_value;
    len_t   instr_length;
  } result_t;

  // instruction classes
  localparam class_t CLS_NOP      = 6'd0;
  localparam class_t CLS_STOP     = 6'd1;
  localparam class_t CLS_HALT     = 6'd2;
  localparam class_t CLS_DI       = 6'd3;
  localparam class_t CLS_EI       = 6'd4;
  localparam class_t CLS_RET      = 6'd5;
  localparam class_t CLS_RETI     = 6'd6;
  localparam class_t CLS_DAA      = 6'd7;
  localparam class_t CLS_CPL      = 6'd8;
  localparam class_t CLS_SCF      = 6'd9;
  localparam class_t CLS_CCF      = 6'd10;
  localparam class_t CLS_RLCA     = 6'd11;
  localparam class_t CLS_RRCA     = 6'd12;
  localparam class_t CLS_RLA      = 6'd13;
  localparam class_t CLS_RRA      = 6'd14;
  localparam class_t CLS_JP_HL    = 6'd15;
  localparam class_t CLS_LD_SP_HL = 6'd16;
  localparam class_t CLS_LD_R_R   = 6'd17;
  localparam class_t CLS_ALU_R    = 6'd18;
  localparam class_t CLS_LD_R_N   = 6'd19;
  localparam class_t CLS_LD_RR_NN = 6'd20;
  localparam class_t CLS_INC_R    = 6'd21;
  localparam class_t CLS_DEC_R    = 6'd22;
  localparam class_t CLS_INC_RR   = 6'd23;
  localparam class_t CLS_DEC_RR   = 6'd24;
  localparam class_t CLS_ADD_HL   = 6'd25;
  localparam class_t CLS_PUSH     = 6'd26;
  localparam class_t CLS_POP      = 6'd27;
  localparam class_t CLS_ALU_N    = 6'd28;
  localparam class_t CLS_JR       = 6'd29;
  localparam class_t CLS_JR_CC    = 6'd30;
  localparam class_t CLS_JP       = 6'd31;
  localparam class_t CLS_JP_CC    = 6'd32;
  localparam class_t CLS_CALL     = 6'd33;
  localparam class_t CLS_CALL_CC  = 6'd34;
  localparam class_t CLS_RET_CC   = 6'd35;
  localparam class_t CLS_RST      = 6'd36;
  localparam class_t CLS_ST_ABS   = 6'd37;
  localparam class_t CLS_LD_ABS   = 6'd38;
  localparam class_t CLS_ST_SP    = 6'd39;
  localparam class_t CLS_LDH_ST   = 6'd40;
  localparam class_t CLS_LDH_LD   = 6'd41;
  localparam class_t CLS_ST_C     = 6'd42;
  localparam class_t CLS_LD_C     = 6'd43;
  localparam class_t CLS_ST_RR    = 6'd44;
  localparam class_t CLS_LD_RR    = 6'd45;
  localparam class_t CLS_ADD_SP   = 6'd46;
  localparam class_t CLS_LD_HL_SP = 6'd47;
  localparam class_t CLS_CB_SHIFT = 6'd48;
  localparam class_t CLS_BIT      = 6'd49;
  localparam class_t CLS_RES      = 6'd50;
  localparam class_t CLS_SET      = 6'd51;
  localparam class_t CLS_DATA     = 6'd52;

  // single opcodes
  localparam byte_t OP_NOP      = 8'h00;
  localparam byte_t OP_STOP     = 8'h10;
  localparam byte_t OP_HALT     = 8'h76;
  localparam byte_t OP_DI       = 8'hF3;
  localparam byte_t OP_EI       = 8'hFB;
  localparam byte_t OP_RET      = 8'hC9;
  localparam byte_t OP_RETI     = 8'hD9;
  localparam byte_t OP_DAA      = 8'h27;
  localparam byte_t OP_CPL      = 8'h2F;
  localparam byte_t OP_SCF      = 8'h37;
  localparam byte_t OP_CCF      = 8'h3F;
  localparam byte_t OP_RLCA     = 8'h07;
  localparam byte_t OP_RRCA     = 8'h0F;
  localparam byte_t OP_RLA      = 8'h17;
  localparam byte_t OP_RRA      = 8'h1F;
  localparam byte_t OP_JP_HL    = 8'hE9;
  localparam byte_t OP_LD_SP_HL = 8'hF9;
  localparam byte_t OP_JR       = 8'h18;
  localparam byte_t OP_JP       = 8'hC3;
  localparam byte_t OP_CALL     = 8'hCD;
  localparam byte_t OP_ST_ABS   = 8'hEA;
  localparam byte_t OP_LD_ABS   = 8'hFA;
  localparam byte_t OP_ST_SP    = 8'h08;
  localparam byte_t OP_LDH_ST   = 8'hE0;
  localparam byte_t OP_LDH_LD   = 8'hF0;
  localparam byte_t OP_ST_C     = 8'hE2;
  localparam byte_t OP_LD_C     = 8'hF2;
  localparam byte_t OP_ADD_SP   = 8'hE8;
  localparam byte_t OP_LD_HL_SP = 8'hF8;
  localparam byte_t OP_PREFIX   = 8'hCB;

  // group masks and patterns
  localparam byte_t MASK_R3   = 8'hC7;
  localparam byte_t MASK_P2   = 8'hCF;
  localparam byte_t MASK_CC   = 8'hE7;
  localparam byte_t RST_MASK  = 8'h38;
  localparam byte_t PAT_LD_N  = 8'h06;
  localparam byte_t PAT_LD_NN = 8'h01;
  localparam byte_t PAT_INC   = 8'h04;
  localparam byte_t PAT_DEC   = 8'h05;
  localparam byte_t PAT_INC2  = 8'h03;
  localparam byte_t PAT_DEC2  = 8'h0B;
  localparam byte_t PAT_ADDHL = 8'h09;
  localparam byte_t PAT_PUSH  = 8'hC5;
  localparam byte_t PAT_POP   = 8'hC1;
  localparam byte_t PAT_ALU_N = 8'hC6;
  localparam byte_t PAT_JR_CC = 8'h20;
  localparam byte_t PAT_JP_CC = 8'hC2;
  localparam byte_t PAT_CL_CC = 8'hC4;
  localparam byte_t PAT_RT_CC = 8'hC0;
  localparam byte_t PAT_RST   = 8'hC7;
  localparam byte_t PAT_ST_RR = 8'h02;
  localparam byte_t PAT_LD_RR = 8'h0A;

  // top two bits select the register-transfer, ALU and prefix groups
  localparam logic [1:0] GRP_LD  = 2'b01;
  localparam logic [1:0] GRP_ALU = 2'b10;
  localparam logic [1:0] CB_SHIFT = 2'b00;
  localparam logic [1:0] CB_BIT   = 2'b01;
  localparam logic [1:0] CB_RES   = 2'b10;

  localparam byte_t HIGH_PAGE = 8'hFF;

  localparam len_t LEN1 = 2'd1;
  localparam len_t LEN2 = 2'd2;
  localparam len_t LEN3 = 2'd3;

endpackage

// ----- sv/opdec_if.sv -----
// ----------------------------------------------------------------------------
// opdec_if
// Valid/ready channels for instruction windows and decoded results.
// ----------------------------------------------------------------------------
interface opdec_in_if;
  logic          valid;
  logic          ready;
  logic [15:0]   instr_address;
  logic [7:0]    opcode_byte;
  logic [7:0]    next_byte;
  logic [7:0]    third_byte;

  modport source (output valid, instr_address, opcode_byte, next_byte, third_byte,
                  input ready);
  modport sink   (input valid, instr_address, opcode_byte, next_byte, third_byte,
                  output ready);
endinterface

interface opdec_out_if;
  logic          valid;
  logic          ready;
  logic [5:0]    instr_class;
  logic [2:0]    first_field;
  logic [2:0]    second_field;
  logic [15:0]   operand_value;
  logic [1:0]    instr_length;

  modport source (output valid, instr_class, first_field, second_field,
                  operand_value, instr_length, input ready);
  modport sink   (input valid, instr_class, first_field, second_field,
                  operand_value, instr_length, output ready);
endinterface

// ----- sv/opdec_decode.sv -----
// ----------------------------------------------------------------------------
// opdec_decode
// Priority decode of one instruction window into class, fields, operand, length.
// ----------------------------------------------------------------------------
module opdec_decode (
  input  opdec_pkg::window_t win,
  output opdec_pkg::result_t res
);
  import opdec_pkg::*;

  byte_t  op;
  byte_t  n;
  addr_t  nn;
  addr_t  disp;
  addr_t  rel;
  field_t r3;
  field_t lo3;
  field_t c2;
  field_t p2;

  assign op   = win.opcode_byte;
  assign n    = win.next_byte;
  assign nn   = {win.third_byte, win.next_byte};
  assign disp = {{(AddrW-ByteW){n[ByteW-1]}}, n};
  // relative target: address past the two-byte instruction plus displacement
  assign rel  = win.instr_address + addr_t'(LEN2) + disp;
  assign r3   = op[5:3];
  assign lo3  = op[2:0];
  assign c2   = {1'b0, op[4:3]};
  assign p2   = {1'b0, op[5:4]};

  always_comb begin
    res = '0;
    res.instr_length = LEN1;
    case (op)
      OP_NOP:      res.instr_class = CLS_NOP;
      OP_STOP: begin
        res.instr_class  = CLS_STOP;
        res.instr_length = LEN2;
      end
      OP_HALT:     res.instr_class = CLS_HALT;
      OP_DI:       res.instr_class = CLS_DI;
      OP_EI:       res.instr_class = CLS_EI;
      OP_RET:      res.instr_class = CLS_RET;
      OP_RETI:     res.instr_class = CLS_RETI;
      OP_DAA:      res.instr_class = CLS_DAA;
      OP_CPL:      res.instr_class = CLS_CPL;
      OP_SCF:      res.instr_class = CLS_SCF;
      OP_CCF:      res.instr_class = CLS_CCF;
      OP_RLCA:     res.instr_class = CLS_RLCA;
      OP_RRCA:     res.instr_class = CLS_RRCA;
      OP_RLA:      res.instr_class = CLS_RLA;
      OP_RRA:      res.instr_class = CLS_RRA;
      OP_JP_HL:    res.instr_class = CLS_JP_HL;
      OP_LD_SP_HL: res.instr_class = CLS_LD_SP_HL;
      default: begin
        if (op[7:6] == GRP_LD) begin
          res.instr_class  = CLS_LD_R_R;
          res.first_field  = r3;
          res.second_field = lo3;
        end else if (op[7:6] == GRP_ALU) begin
          res.instr_class  = CLS_ALU_R;
          res.first_field  = r3;
          res.second_field = lo3;
        end else if ((op & MASK_R3) == PAT_LD_N) begin
          res.instr_class   = CLS_LD_R_N;
          res.first_field   = r3;
          res.operand_value = addr_t'(n);
          res.instr_length  = LEN2;
        end else if ((op & MASK_P2) == PAT_LD_NN) begin
          res.instr_class   = CLS_LD_RR_NN;
          res.first_field   = p2;
          res.operand_value = nn;
          res.instr_length  = LEN3;
        end else if ((op & MASK_R3) == PAT_INC) begin
          res.instr_class = CLS_INC_R;
          res.first_field = r3;
        end else if ((op & MASK_R3) == PAT_DEC) begin
          res.instr_class = CLS_DEC_R;
          res.first_field = r3;
        end else if ((op & MASK_P2) == PAT_INC2) begin
          res.instr_class = CLS_INC_RR;
          res.first_field = p2;
        end else if ((op & MASK_P2) == PAT_DEC2) begin
          res.instr_class = CLS_DEC_RR;
          res.first_field = p2;
        end else if ((op & MASK_P2) == PAT_ADDHL) begin
          res.instr_class = CLS_ADD_HL;
          res.first_field = p2;
        end else if ((op & MASK_P2) == PAT_PUSH) begin
          res.instr_class = CLS_PUSH;
          res.first_field = p2;
        end else if ((op & MASK_P2) == PAT_POP) begin
          res.instr_class = CLS_POP;
          res.first_field = p2;
        end else if ((op & MASK_R3) == PAT_ALU_N) begin
          res.instr_class   = CLS_ALU_N;
          res.first_field   = r3;
          res.operand_value = addr_t'(n);
          res.instr_length  = LEN2;
        end else if (op == OP_JR) begin
          res.instr_class   = CLS_JR;
          res.operand_value = rel;
          res.instr_length  = LEN2;
        end else if ((op & MASK_CC) == PAT_JR_CC) begin
          res.instr_class   = CLS_JR_CC;
          res.first_field   = c2;
          res.operand_value = rel;
          res.instr_length  = LEN2;
        end else if (op == OP_JP) begin
          res.instr_class   = CLS_JP;
          res.operand_value = nn;
          res.instr_length  = LEN3;
        end else if ((op & MASK_CC) == PAT_JP_CC) begin
          res.instr_class   = CLS_JP_CC;
          res.first_field   = c2;
          res.operand_value = nn;
          res.instr_length  = LEN3;
        end else if (op == OP_CALL) begin
          res.instr_class   = CLS_CALL;
          res.operand_value = nn;
          res.instr_length  = LEN3;
        end else if ((op & MASK_CC) == PAT_CL_CC) begin
          res.instr_class   = CLS_CALL_CC;
          res.first_field   = c2;
          res.operand_value = nn;
          res.instr_length  = LEN3;
        end else if ((op & MASK_CC) == PAT_RT_CC) begin
          res.instr_class = CLS_RET_CC;
          res.first_field = c2;
        end else if ((op & MASK_R3) == PAT_RST) begin
          res.instr_class   = CLS_RST;
          res.operand_value = addr_t'(op & RST_MASK);
        end else if (op == OP_ST_ABS) begin
          res.instr_class   = CLS_ST_ABS;
          res.operand_value = nn;
          res.instr_length  = LEN3;
        end else if (op == OP_LD_ABS) begin
          res.instr_class   = CLS_LD_ABS;
          res.operand_value = nn;
          res.instr_length  = LEN3;
        end else if (op == OP_ST_SP) begin
          res.instr_class   = CLS_ST_SP;
          res.operand_value = nn;
          res.instr_length  = LEN3;
        end else if (op == OP_LDH_ST) begin
          res.instr_class   = CLS_LDH_ST;
          res.operand_value = {HIGH_PAGE, n};
          res.instr_length  = LEN2;
        end else if (op == OP_LDH_LD) begin
          res.instr_class   = CLS_LDH_LD;
          res.operand_value = {HIGH_PAGE, n};
          res.instr_length  = LEN2;
        end else if (op == OP_ST_C) begin
          res.instr_class = CLS_ST_C;
        end else if (op == OP_LD_C) begin
          res.instr_class = CLS_LD_C;
        end else if ((op & MASK_P2) == PAT_ST_RR) begin
          res.instr_class = CLS_ST_RR;
          res.first_field = p2;
        end else if ((op & MASK_P2) == PAT_LD_RR) begin
          res.instr_class = CLS_LD_RR;
          res.first_field = p2;
        end else if (op == OP_ADD_SP) begin
          res.instr_class   = CLS_ADD_SP;
          res.operand_value = disp;
          res.instr_length  = LEN2;
        end else if (op == OP_LD_HL_SP) begin
          res.instr_class   = CLS_LD_HL_SP;
          res.operand_value = disp;
          res.instr_length  = LEN2;
        end else if (op == OP_PREFIX) begin
          case (n[7:6])
            CB_SHIFT: res.instr_class = CLS_CB_SHIFT;
            CB_BIT:   res.instr_class = CLS_BIT;
            CB_RES:   res.instr_class = CLS_RES;
            default:  res.instr_class = CLS_SET;
          endcase
          res.first_field  = n[5:3];
          res.second_field = n[2:0];
          res.instr_length = LEN2;
        end else begin
          // undefined opcode shows up as a data byte
          res.instr_class   = CLS_DATA;
          res.operand_value = addr_t'(op);
        end
      end
    endcase
  end

endmodule

// ----- sv/eight_bit_opcode_decoder.sv -----
// ----------------------------------------------------------------------------
// eight_bit_opcode_decoder
// Two-register pipeline around the opcode decode: window register, result
// register, one item per cycle while decoded does not stall.
//
//   channel   role    payload
//   instr     sink    instr_address, opcode_byte, next_byte, third_byte
//   decoded   source  instr_class, first_field, second_field,
//                     operand_value, instr_length
//
// an item accepted on instr passes the window register and then the result
// register, from which it is offered on decoded
// sustained rate is one item per cycle while decoded does not stall, set by the single decode stage
// rst is synchronous and empties both registers
// a stall on decoded holds the result register; the window register keeps
// taking an item as long as one of the two registers has room
// ----------------------------------------------------------------------------
module eight_bit_opcode_decoder (
  input logic        clk,
  input logic        rst,
  opdec_in_if.sink   instr,
  opdec_out_if.source decoded
);
  import opdec_pkg::*;

  logic    win_valid;
  window_t win;
  logic    res_valid;
  result_t res;
  result_t res_next;
  logic    res_load;
  logic    win_load;

  opdec_decode u_decode (
    .win (win),
    .res (res_next)
  );

  assign res_load    = !res_valid || decoded.ready;
  assign win_load    = !win_valid || res_load;
  assign instr.ready = win_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (win_load) begin
        win_valid <= instr.valid;
      end
      if (res_load) begin
        res_valid <= win_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (win_load && instr.valid) begin
      win.instr_address <= instr.instr_address;
      win.opcode_byte   <= instr.opcode_byte;
      win.next_byte     <= instr.next_byte;
      win.third_byte    <= instr.third_byte;
    end
    if (res_load && win_valid) begin
      res <= res_next;
    end
  end

  assign decoded.valid         = res_valid;
  assign decoded.instr_class   = res.instr_class;
  assign decoded.first_field   = res.first_field;
  assign decoded.second_field  = res.second_field;
  assign decoded.operand_value = res.operand_value;
  assign decoded.instr_length  = res.instr_length;

  // a window held back by a full result register stays put
  a_win_hold: assert property (@(posedge clk) disable iff (rst)
    (win_valid && !res_load) |=> (win_valid && $stable(win)))
    else $error("window register lost an item while stalled");

  // a decoded window always lands in the result register
  a_win_to_res: assert property (@(posedge clk) disable iff (rst)
    (win_valid && res_load) |=> res_valid)
    else $error("decoded item dropped");

  // every result carries a length of one to three bytes
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.instr_length != 2'd0))
    else $error("zero instruction length");

  // data bytes are one byte long with empty fields
  a_data_byte: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.instr_class == CLS_DATA) |->
      (res.instr_length == LEN1 && res.first_field == '0 && res.second_field == '0))
    else $error("malformed data byte result");

endmodule
